@@ rtl/twqs_pkg.sv @@
// shared constants and types of the three-way quicksort engine
// no dependencies; compiled first
package twqs_pkg;

	localparam int unsigned DATA_W           = 32;
	localparam int unsigned MAX_ELEMENTS_DEF = 64;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic                     load;
		logic signed [DATA_W-1:0] value;
		logic                     eol;
		logic                     ovf;
	} res_t;

endpackage

@@ rtl/twqs_in_if.sv @@
// input channel of the quicksort engine: valid/ready plus one list element
// depends on twqs_pkg
interface twqs_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [twqs_pkg::DATA_W-1:0] value;
	logic                              is_last;

	modport source(output valid, value, is_last, input ready);
	modport sink(input valid, value, is_last, output ready);
endinterface

@@ rtl/twqs_out_if.sv @@
// output channel of the quicksort engine: valid/ready plus one sorted element
// depends on twqs_pkg
interface twqs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [twqs_pkg::DATA_W-1:0] sorted_value;
	logic                              end_of_list;
	logic                              overflow;

	modport source(output valid, sorted_value, end_of_list, overflow, input ready);
	modport sink(input valid, sorted_value, end_of_list, overflow, output ready);
endinterface

@@ rtl/twqs_core.sv @@
// sequencer of the quicksort engine: element store, range stack and the
// shared compare / index unit; depends on twqs_pkg and twqs_in_if
module twqs_core #(
	parameter int unsigned MAX_ELEMENTS = twqs_pkg::MAX_ELEMENTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	twqs_in_if.sink         in_ch,
	input  logic            out_busy,
	output twqs_pkg::res_t  res
);

	localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
	localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned STK_W = 2 * CNT_W;
	localparam int unsigned DW    = twqs_pkg::DATA_W;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_RNG  = 14'b00000000000010,
		ST_PIVW = 14'b00000000000100,
		ST_SCAN = 14'b00000000001000,
		ST_CMP  = 14'b00000000010000,
		ST_WI   = 14'b00000000100000,
		ST_GTR  = 14'b00000001000000,
		ST_GTW  = 14'b00000010000000,
		ST_PUSH = 14'b00000100000000,
		ST_POP  = 14'b00001000000000,
		ST_POPW = 14'b00010000000000,
		ST_ORD  = 14'b00100000000000,
		ST_OLD  = 14'b01000000000000,
		ST_SPARE = 14'b10000000000000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q, lo_q, hi_q, lt_q, i_q, gt_q, sp_q, oidx_q;
	logic                   dropped_q;
	logic signed [DW-1:0]   pivot_q, k_q, rd_q;
	logic [STK_W-1:0]       st_rd_q;

	logic signed [DW-1:0]   store_mem [MAX_ELEMENTS];
	logic [STK_W-1:0]       stack_mem [MAX_ELEMENTS];

	logic                   in_fire, room;
	logic [CNT_W-1:0]       count_inc, len, mid, gt_dec, left_len, right_len;
	logic [CNT_W-1:0]       sp_dec, oidx_inc;
	logic                   is_less, is_greater, stk_room;

	logic                   we, re, stk_we, stk_re;
	logic [IDX_W-1:0]       waddr, raddr;
	logic signed [DW-1:0]   wdata;
	logic [STK_W-1:0]       stk_wdata;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign room         = count_q < CNT_W'(MAX_ELEMENTS);
	assign count_inc    = count_q + 1'b1;
	assign len          = hi_q - lo_q;
	assign mid          = lo_q + (len >> 1);
	assign gt_dec       = gt_q - 1'b1;
	assign left_len     = lt_q - lo_q;
	assign right_len    = hi_q - gt_q;
	assign sp_dec       = sp_q - 1'b1;
	assign oidx_inc     = oidx_q + 1'b1;
	assign stk_room     = sp_q < CNT_W'(MAX_ELEMENTS);

	// shared three-way compare against the pivot
	assign is_less      = rd_q < pivot_q;
	assign is_greater   = rd_q > pivot_q;

	// store port selection
	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = in_ch.value;
		re    = 1'b0;
		raddr = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				we = in_fire && room;
			end
			ST_RNG: begin
				re    = 1'b1;
				raddr = mid[IDX_W-1:0];
			end
			ST_SCAN: begin
				re = 1'b1;
			end
			ST_CMP: begin
				if (is_less && (lt_q != i_q)) begin
					we    = 1'b1;
					waddr = lt_q[IDX_W-1:0];
					wdata = rd_q;
				end else if (is_greater) begin
					re    = 1'b1;
					raddr = gt_dec[IDX_W-1:0];
				end
			end
			ST_WI: begin
				we    = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = pivot_q;
			end
			ST_GTR: begin
				we    = 1'b1;
				waddr = gt_q[IDX_W-1:0];
				wdata = k_q;
			end
			ST_GTW: begin
				we    = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = rd_q;
			end
			ST_ORD: begin
				re    = !out_busy;
				raddr = oidx_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// stack port selection: larger part is pushed
	always_comb begin
		stk_we    = (state_q == ST_PUSH) && stk_room &&
			((left_len < right_len) ? (right_len > CNT_W'(1)) : (left_len > CNT_W'(1)));
		stk_wdata = (left_len < right_len) ? {gt_q, hi_q} : {lo_q, lt_q};
		stk_re    = (state_q == ST_POP) && (sp_q != '0);
	end

	always_ff @(posedge clk) begin
		if (we) store_mem[waddr] <= wdata;
		if (re) rd_q <= store_mem[raddr];
		if (stk_we) stack_mem[sp_q[IDX_W-1:0]] <= stk_wdata;
		if (stk_re) st_rd_q <= stack_mem[sp_dec[IDX_W-1:0]];
		if (state_q == ST_PIVW) pivot_q <= rd_q;
		if (state_q == ST_CMP) k_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			lt_q      <= '0;
			i_q       <= '0;
			gt_q      <= '0;
			sp_q      <= '0;
			oidx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (room) count_q <= count_inc;
						else dropped_q <= 1'b1;
						if (in_ch.is_last) begin
							lo_q    <= '0;
							hi_q    <= room ? count_inc : count_q;
							sp_q    <= '0;
							state_q <= ST_RNG;
						end
					end
				end
				ST_RNG: begin
					if (len <= CNT_W'(1)) state_q <= ST_POP;
					else state_q <= ST_PIVW;
				end
				ST_PIVW: begin
					lt_q    <= lo_q;
					i_q     <= lo_q;
					gt_q    <= hi_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (i_q < gt_q) state_q <= ST_CMP;
					else state_q <= ST_PUSH;
				end
				ST_CMP: begin
					if (is_less) begin
						if (lt_q != i_q) begin
							state_q <= ST_WI;
						end else begin
							lt_q    <= lt_q + 1'b1;
							i_q     <= i_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end else if (is_greater) begin
						gt_q    <= gt_dec;
						state_q <= ST_GTR;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_WI: begin
					lt_q    <= lt_q + 1'b1;
					i_q     <= i_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_GTR: begin
					state_q <= ST_GTW;
				end
				ST_GTW: begin
					state_q <= ST_SCAN;
				end
				ST_PUSH: begin
					if (stk_we) sp_q <= sp_q + 1'b1;
					if (left_len < right_len) hi_q <= lt_q;
					else lo_q <= gt_q;
					state_q <= ST_RNG;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						oidx_q  <= '0;
						state_q <= ST_ORD;
					end else begin
						sp_q    <= sp_dec;
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					lo_q    <= st_rd_q[STK_W-1:CNT_W];
					hi_q    <= st_rd_q[CNT_W-1:0];
					state_q <= ST_RNG;
				end
				ST_ORD: begin
					if (!out_busy) state_q <= ST_OLD;
				end
				ST_OLD: begin
					if (oidx_inc == count_q) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						oidx_q  <= oidx_inc;
						state_q <= ST_ORD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.load  = (state_q == ST_OLD);
	assign res.value = rd_q;
	assign res.eol   = (oidx_inc == count_q);
	assign res.ovf   = dropped_q;

endmodule

@@ rtl/twqs_out_stage.sv @@
// output register of the quicksort engine, holds one result until transfer
// depends on twqs_pkg and twqs_out_if
module twqs_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  twqs_pkg::res_t  res,
	output logic            busy,
	twqs_out_if.source      out_ch
);

	logic                              valid_q;
	logic signed [twqs_pkg::DATA_W-1:0] value_q;
	logic                              eol_q;
	logic                              ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.load) begin
			valid_q <= 1'b1;
		end else if (valid_q && out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			value_q <= res.value;
			eol_q   <= res.eol;
			ovf_q   <= res.ovf;
		end
	end

	assign busy                = valid_q;
	assign out_ch.valid        = valid_q;
	assign out_ch.sorted_value = value_q;
	assign out_ch.end_of_list  = eol_q;
	assign out_ch.overflow     = ovf_q;

endmodule

@@ rtl/three_way_quicksort_engine.sv @@
// top level of the three-way quicksort engine
// depends on twqs_pkg, twqs_in_if, twqs_out_if, twqs_core, twqs_out_stage
//
// usage:
//  - in_ch carries one signed 32-bit element per transfer; is_last closes the list
//  - while loading, in_ch.ready is high and each element takes one cycle
//  - up to MAX_ELEMENTS elements are kept; later ones are dropped and every
//    result of that list has overflow set
//  - after the is_last transfer, in_ch.ready drops and the store is sorted in place
//    by three-way quicksort, one element compared per step by a shared compare
//    unit; an element equal to the pivot or already in place passes the scan and
//    compare states, one that is less and swapped also a write-back state, and one
//    that is greater the states that swap it with the top end (the swapped-in
//    element is scanned again)
//  - the sorted list leaves on out_ch, one result at a time: the next element is
//    read only once the output register is empty; end_of_list marks the final result
//  - a stalled receiver holds the output register; the sequencer waits on it
//  - the final result may still wait in the output register while the next
//    list already loads
//  - reset clears counters, the overflow flag and the output valid; the store
//    needs no clearing, only loaded entries are ever read
module three_way_quicksort_engine #(
	parameter int unsigned MAX_ELEMENTS = twqs_pkg::MAX_ELEMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	twqs_in_if.sink     in_ch,
	twqs_out_if.source  out_ch
);

	twqs_pkg::res_t res;   // result handed to the output register
	logic           out_busy;

	// sequencer, store and range stack
	twqs_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_busy(out_busy),
		.res     (res)
	);

	// output register decouples the receiver from the sequencer
	twqs_out_stage u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.res   (res),
		.busy  (out_busy),
		.out_ch(out_ch)
	);

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> !out_busy)
		else $error("result loaded while output register full");

	// no input transfer while results are being produced
	a_no_load_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> !in_ch.ready)
		else $error("input ready during output burst");

	// loading resumes only once the final result of the list is out or waiting
	a_resume_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ch.ready) |-> (!out_ch.valid || out_ch.end_of_list))
		else $error("input ready before end of list");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for three_way_quicksort_engine: random and directed lists
// depends on twqs_pkg, twqs_in_if, twqs_out_if and the engine rtl
// expected bursts come from an ascending signed sort of each accepted list
module testbench;

	localparam int unsigned CAPACITY   = twqs_pkg::MAX_ELEMENTS_DEF;
	localparam int unsigned IDLE_LIMIT = 200000;   // worst-case sort of a full store fits many times
	localparam int unsigned DRAIN      = 40;

	typedef logic signed [twqs_pkg::DATA_W-1:0] elem_t;

	localparam elem_t VAL_MIN = {1'b1, {(twqs_pkg::DATA_W-1){1'b0}}};
	localparam elem_t VAL_MAX = {1'b0, {(twqs_pkg::DATA_W-1){1'b1}}};

	// one result as it should leave the engine
	typedef struct {
		elem_t value;
		bit    eol;
		bit    ovf;
	} sorted_elem_t;

	// collects accepted elements, sorts each closed list and checks the burst
	class sort_scoreboard;
		elem_t        open_list[$];
		bit           dropped;
		sorted_elem_t burst_q[$];
		int           errors;

		function void note_element(elem_t v, bit last);
			elem_t        key;
			int           j;
			sorted_elem_t r;
			if (open_list.size() < CAPACITY) begin
				open_list.push_back(v);
			end else begin
				dropped = 1'b1;
			end
			if (!last) begin
				return;
			end
			// insertion sort, signed ascending
			for (int i = 1; i < open_list.size(); i++) begin
				key = open_list[i];
				j = i - 1;
				while (j >= 0 && open_list[j] > key) begin
					open_list[j+1] = open_list[j];
					j--;
				end
				open_list[j+1] = key;
			end
			foreach (open_list[k]) begin
				r.value = open_list[k];
				r.eol   = (k == open_list.size() - 1);
				r.ovf   = dropped;
				burst_q.push_back(r);
			end
			open_list.delete();
			dropped = 1'b0;
		endfunction

		function void check_result(elem_t v, logic eol, logic ovf);
			sorted_elem_t e;
			if (burst_q.size() == 0) begin
				$error("unexpected result: sorted_value %0d", v);
				errors++;
				return;
			end
			e = burst_q.pop_front();
			if (v !== e.value) begin
				$error("sorted_value: expected %0d, got %0d", e.value, v);
				errors++;
			end
			if (eol !== e.eol) begin
				$error("end_of_list: expected %0b, got %0b", e.eol, eol);
				errors++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow: expected %0b, got %0b", e.ovf, ovf);
				errors++;
			end
		endfunction

		function int pending();
			return burst_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	twqs_in_if  in_ch();
	twqs_out_if out_ch();

	three_way_quicksort_engine uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	sort_scoreboard sb = new();

	bit    steady;      // when set, neither side idles
	elem_t list_buf[$];
	int    idle_cycles;
	int    items_sent;  // input transfers so far

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// pick a value: extremes, a narrow band that makes duplicates, or anything
	function automatic elem_t pick_value();
		case ($urandom_range(0, 5))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return elem_t'($urandom_range(0, 8)) - elem_t'(4);
			3: return ($urandom_range(0, 1) != 0) ? elem_t'(0) : elem_t'(-1);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// one input transfer; entered and left at a falling edge
	task automatic send_element(elem_t v, bit last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.value   <= v;
		in_ch.is_last <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_element(v, last);
		items_sent++;
		@(negedge clk);
	endtask

	// sends list_buf with is_last on its final element
	task automatic send_list();
		foreach (list_buf[k]) begin
			send_element(list_buf[k], k == list_buf.size() - 1);
		end
	endtask

	task automatic send_random_list(int len);
		steady = ($urandom_range(0, 3) == 0);
		list_buf.delete();
		repeat (len) list_buf.push_back(pick_value());
		send_list();
	endtask

	// stimulus and end of run
	initial begin
		int len;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.value   = '0;
		in_ch.is_last = 1'b0;
		steady        = 1'b0;
		items_sent    = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single element, extremes mixed, all equal, sorted, reversed, pair
		list_buf = '{VAL_MIN};
		send_list();
		list_buf = '{VAL_MAX, VAL_MIN, elem_t'(0), elem_t'(-1), elem_t'(1)};
		send_list();
		list_buf = '{elem_t'(7), elem_t'(7), elem_t'(7), elem_t'(7)};
		send_list();
		list_buf = '{elem_t'(-2), elem_t'(1), elem_t'(2), elem_t'(3), VAL_MAX};
		send_list();
		list_buf = '{VAL_MAX, elem_t'(4), elem_t'(0), elem_t'(-3), VAL_MIN};
		send_list();
		list_buf = '{elem_t'(2), elem_t'(-2)};
		send_list();

		// one more than full: the store fills and the is_last transfer is dropped
		send_random_list(CAPACITY + 1);

		// short lists with random content
		while (items_sent < 120) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
			send_random_list(len);
		end
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// result side: random stalls, checks every transfer
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_result(out_ch.sorted_value, out_ch.end_of_list, out_ch.overflow);
			@(negedge clk);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

@@ three_way_quicksort_engine.f @@
rtl/twqs_pkg.sv
rtl/twqs_in_if.sv
rtl/twqs_out_if.sv
rtl/twqs_core.sv
rtl/twqs_out_stage.sv
rtl/three_way_quicksort_engine.sv
tb/testbench.sv
